// ===== src/tfkbm_pkg.sv =====
// Package with shared types and constants of the touch frame to key and beam map.
`default_nettype none
package tfkbm_pkg;
   localparam int TravelWidth = 18;

   typedef struct packed {
      logic [31:0]        touch_id;
      logic signed [15:0] touch_x;
      logic signed [15:0] touch_y;
      logic               is_down;
      logic               is_up;
      logic               last_in_frame;
   } point_type;

   typedef struct packed {
      logic        hand_tracker_mode;
      logic        keep_keys_on_lift;
      logic [15:0] lift_threshold;
      logic [15:0] beam_step;
      logic signed [15:0] keys_start_x;
      logic [9:0]  key_width;
   } cfg_type;

   typedef enum logic [2:0] {
      CSR_HAND  = 3'd0,
      CSR_KEEP  = 3'd1,
      CSR_LIFT  = 3'd2,
      CSR_STEP  = 3'd3,
      CSR_START = 3'd4,
      CSR_KEYW  = 3'd5
   } csr_index_type;
endpackage
`default_nettype wire

// ===== src/touch_frame_to_key_beam_map_core.sv =====
// Top level of the touch frame to key and beam map.
// Channel | Dir | Fields
// req     | in  | tdata: touch_id[31:0] touch_x[47:32] touch_y[63:48] is_down is_up; tlast
// rsp     | out | tdata: key_map[31:0] beam_map[37:32] table_full[38]
// csr     | in  | write enable, index, 16-bit data
// A point goes through a slot search, one slot per cycle, then two 18-step serial
// divisions in parallel; up and dropped points do not wait for the divisions.
// The queue holds two points, including the one the back part works on.
// Reset is synchronous and clears all slot valid bits and frame maps at once.
// A result waits in its register; the back part stalls until it is taken.
`default_nettype none
module touch_frame_to_key_beam_map_core #(
   parameter int MAX_TOUCHES = 10,
   parameter int KEY_COUNT   = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [71:0]  req_tdata, // touch_id, touch_x, touch_y, is_down, is_up
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata, // key_map, beam_map, table_full
   input  wire         csr_we,
   input  wire [2:0]   csr_index,
   input  wire [15:0]  csr_wdata
);
   import tfkbm_pkg::*;
   cfg_type   cfg_ff;
   point_type in_pt, q_pt;
   logic      q_valid, q_ready;

   always_comb begin
      in_pt.touch_id      = req_tdata[31:0];
      in_pt.touch_x       = req_tdata[47:32];
      in_pt.touch_y       = req_tdata[63:48];
      in_pt.is_down       = req_tdata[64];
      in_pt.is_up         = req_tdata[65];
      in_pt.last_in_frame = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{1'b0, 1'b0, 16'd70, 16'd50, 16'sd318, 10'd40};
      end else if (csr_we) begin
         case (csr_index)
            CSR_HAND:  cfg_ff.hand_tracker_mode <= csr_wdata[0];
            CSR_KEEP:  cfg_ff.keep_keys_on_lift <= csr_wdata[0];
            CSR_LIFT:  cfg_ff.lift_threshold    <= csr_wdata;
            CSR_STEP:  cfg_ff.beam_step         <= csr_wdata;
            CSR_START: cfg_ff.keys_start_x      <= csr_wdata;
            CSR_KEYW:  cfg_ff.key_width         <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   tfkbm_queue u_queue (.clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(in_pt), .out_valid(q_valid), .out_ready(q_ready), .out_data(q_pt));

   tfkbm_back #(.MaxTouches(MAX_TOUCHES), .KeyCount(KEY_COUNT)) u_back (
      .clock, .reset, .cfg(cfg_ff), .pt_valid(q_valid), .pt_ready(q_ready), .pt(q_pt),
      .rsp_tvalid, .rsp_tready, .rsp_tdata);
endmodule
`default_nettype wire

// ===== src/tfkbm_queue.sv =====
// Short queue of accepted touch points between the front and back parts.
`default_nettype none
module tfkbm_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  tfkbm_pkg::point_type  in_data,
   output logic                  out_valid,
   input  wire                   out_ready,
   output tfkbm_pkg::point_type  out_data
);
   import tfkbm_pkg::*;
   point_type mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wptr_ff, rptr_ff;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
      end
      if (push) mem_ff[wptr_ff] <= in_data;
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) count_ff == 2'd2 |-> !push;
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count slip");
   a_empty_no_out: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 |-> !out_valid) else $error("empty queue valid");
endmodule
`default_nettype wire

// ===== src/tfkbm_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module tfkbm_divider #(
   parameter int Width = 18
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire [Width-1:0]   dividend,
   input  wire [Width-1:0]   divisor,
   output logic              done,
   output logic [Width-1:0]  quotient
);
   localparam int CountWidth = $clog2(Width + 1);
   logic [Width-1:0]      rem_ff, rem_in, quo_ff, dsr_ff;
   logic [CountWidth-1:0] cnt_ff;
   logic                  busy_ff;
   logic [Width:0]        trial;

   assign trial    = {rem_ff, quo_ff[Width-1]};
   assign quotient = quo_ff;
   assign done     = busy_ff && (cnt_ff == CountWidth'(0));
   assign rem_in   = (trial >= {1'b0, dsr_ff}) ? Width'(trial - {1'b0, dsr_ff})
                                               : trial[Width-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CountWidth'(Width);
         rem_ff  <= '0;
         quo_ff  <= dividend;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         if (cnt_ff == CountWidth'(0)) begin
            busy_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_ff - CountWidth'(1);
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[Width-2:0], (trial >= {1'b0, dsr_ff})};
         end
      end
   end
endmodule
`default_nettype wire

// ===== src/tfkbm_back.sv =====
// Back part: slot search, travel and key/beam evaluation, frame result register.
`default_nettype none
module tfkbm_back #(
   parameter int MaxTouches = 10,
   parameter int KeyCount   = 32
) (
   input  wire                  clock,
   input  wire                  reset,
   input  tfkbm_pkg::cfg_type   cfg,
   input  wire                  pt_valid,
   output logic                 pt_ready,
   input  tfkbm_pkg::point_type pt,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [39:0]          rsp_tdata
);
   import tfkbm_pkg::*;
   localparam int SlotW = $clog2(MaxTouches + 1);
   localparam int KeyW  = $clog2(KeyCount + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001, ST_SRCH = 5'b00010, ST_DIV = 5'b00100,
      ST_WAIT = 5'b01000, ST_OUT = 5'b10000
   } state_type;

   state_type state_ff;
   logic [31:0] slot_id_ff [MaxTouches];
   logic [MaxTouches-1:0] valid_ff;
   logic signed [15:0] start_y_ff [MaxTouches];
   logic [31:0] keys_ff;
   logic [5:0]  beams_ff;
   logic        drop_ff;
   logic [SlotW-1:0] idx_ff, free_ff;
   logic        free_found_ff, hit_ff;
   logic [SlotW-1:0] slot_ff;
   logic signed [17:0] off_ff;
   logic        do_beam_ff, do_key_ff;
   logic        div_start, bdone, kdone;
   logic [17:0] bquo, kquo;
   logic        bdone_ff, kdone_ff;
   logic [31:0] out_keys_ff;
   logic [5:0]  out_beams_ff;
   logic        out_drop_ff, out_valid_ff;
   logic [SlotW-1:0] idx;
   logic signed [17:0] travel_c;
   logic        past;
   logic [2:0]  bq, bsw;
   logic [KeyW-1:0] kidx;
   logic signed [17:0] trav_use;
   logic        past_use;

   assign idx = idx_ff;
   // The point stays at the queue head until its evaluation is finished.
   assign pt_ready = (state_ff == ST_OUT);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {1'b0, out_drop_ff, out_beams_ff, out_keys_ff};

   assign travel_c = 18'(start_y_ff[slot_ff]) - 18'(pt.touch_y);
   assign past = travel_c > $signed({2'b00, cfg.lift_threshold});
   assign trav_use = pt.is_down ? 18'sd0 : travel_c;
   assign past_use = pt.is_down ? (18'sd0 > $signed({2'b00, cfg.lift_threshold})) : past;

   tfkbm_divider #(.Width(18)) u_bdiv (.clock, .reset, .start(div_start),
      .dividend(trav_use), .divisor({2'b00, cfg.beam_step}), .done(bdone),
      .quotient(bquo));
   tfkbm_divider #(.Width(18)) u_kdiv (.clock, .reset, .start(div_start),
      .dividend(off_ff), .divisor({8'd0, cfg.key_width}), .done(kdone),
      .quotient(kquo));

   always_comb begin
      if (cfg.beam_step == 16'd0 || bquo > 18'd6) bq = 3'd5;
      else if (bquo == 18'd0) bq = 3'd0;
      else bq = 3'(bquo - 18'd1);
      bsw = {bq[2:1], !bq[0]};
      kidx = KeyW'(KeyCount - 1) - KeyW'(kquo);
   end

   assign div_start = (state_ff == ST_DIV);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         keys_ff <= '0; beams_ff <= '0; drop_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MaxTouches; i++) start_y_ff[i] <= '0;
      end else begin
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (pt_valid && !out_valid_ff) begin
               idx_ff <= '0; hit_ff <= 1'b0; free_found_ff <= 1'b0;
               state_ff <= ST_SRCH;
            end
            ST_SRCH: begin
               // One slot per cycle; the first hit wins, else the lowest free slot.
               if (valid_ff[idx] && slot_id_ff[idx] == pt.touch_id) begin
                  hit_ff <= 1'b1; slot_ff <= idx; state_ff <= ST_DIV;
               end else begin
                  if (!valid_ff[idx] && !free_found_ff) begin
                     free_found_ff <= 1'b1; free_ff <= idx;
                  end
                  if (idx == SlotW'(MaxTouches - 1)) begin
                     state_ff <= ST_DIV;
                     slot_ff <= (!valid_ff[idx] && !free_found_ff) ? idx : free_ff;
                  end
                  idx_ff <= idx + SlotW'(1);
               end
            end
            ST_DIV: begin
               bdone_ff <= 1'b0; kdone_ff <= 1'b0;
               if (!hit_ff && !free_found_ff) begin
                  drop_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else if (pt.is_up) begin
                  valid_ff[slot_ff] <= 1'b0;
                  state_ff <= ST_OUT;
               end else begin
                  if (!hit_ff) begin
                     valid_ff[slot_ff] <= 1'b1;
                     slot_id_ff[slot_ff] <= pt.touch_id;
                  end
                  if (pt.is_down) start_y_ff[slot_ff] <= pt.touch_y;
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (bdone) bdone_ff <= 1'b1;
               if (kdone) kdone_ff <= 1'b1;
               if ((bdone || bdone_ff) && (kdone || kdone_ff)) begin
                  if (do_beam_ff) beams_ff[bsw] <= 1'b1;
                  if (do_key_ff && cfg.key_width != 10'd0 && !off_ff[17] &&
                      kquo < 18'(KeyCount) && kidx < KeyW'(32))
                     keys_ff[5'(kidx)] <= 1'b1;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (pt.last_in_frame) begin
                  out_keys_ff <= keys_ff; out_beams_ff <= beams_ff;
                  out_drop_ff <= drop_ff; out_valid_ff <= 1'b1;
                  keys_ff <= '0; beams_ff <= '0; drop_ff <= 1'b0;
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // The key offset is taken during the search; the point is stable then.
   always_ff @(posedge clock) begin
      if (state_ff == ST_SRCH) begin
         off_ff <= 18'(pt.touch_x) - 18'(cfg.keys_start_x);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV) begin
         do_beam_ff <= !cfg.hand_tracker_mode && past_use;
         do_key_ff  <= cfg.hand_tracker_mode || !past_use || cfg.keep_keys_on_lift;
      end
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |=> out_valid_ff) else $error("result lost");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_OUT |-> !pt_ready) else $error("accept while busy");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
endmodule
`default_nettype wire
